// File: design/aes_pkg.sv
// Package with AES constants, S-box tables and round helper functions.
package aes_pkg;

  localparam int unsigned RoundCount = 10;
  localparam int unsigned KeyWords   = 4 * (RoundCount + 1);
  localparam int unsigned RegIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;

  typedef enum logic [RegIdxW-1:0] {
    REG_KEY_HIGH = 3'd0,
    REG_KEY_LOW  = 3'd1,
    REG_IV_HIGH  = 3'd2,
    REG_IV_LOW   = 3'd3,
    REG_DECRYPT  = 3'd4,
    REG_CHAIN    = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ROUND = 2'd1,
    ST_DONE  = 2'd2
  } core_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic decrypt;
  } core_ctrl_t;

  function automatic logic [7:0] fwd_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {fwd_sbox(w[31:24]), fwd_sbox(w[23:16]), fwd_sbox(w[15:8]), fwd_sbox(w[7:0])};
  endfunction

endpackage

// File: design/aes_stream_if.sv
// Valid/ready channel carrying one AES block word and its flags.
interface aes_stream_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  logic        start;
  logic        last;

  modport source (output valid, data_high, data_low, start, last, input ready);
  modport sink   (input valid, data_high, data_low, start, last, output ready);
endinterface

// File: design/aes_key_exp.sv
// Key schedule unit: expands all round keys after reset and whenever a key register changes.
module aes_key_exp #(
  parameter int unsigned ROUND_COUNT = aes_pkg::RoundCount
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [127:0] key_i,
  input  logic         restart_i,
  input  logic [3:0]   round_i,
  output logic [127:0] round_key_o,
  output logic         busy_o
);
  import aes_pkg::*;

  // One round key (four words) is produced per cycle and kept in flops. The first
  // expansion step reads the key registers directly, so the schedule also exists
  // after reset without any write.
  logic [127:0] rk_q [ROUND_COUNT+1];
  logic [3:0]   cnt_q, cnt_d;
  logic [7:0]   rcon_q, rcon_d;
  logic         busy_q, busy_d;
  logic [127:0] prev;
  logic [31:0]  t, w0, w1, w2, w3;

  assign prev = (cnt_q == 4'd1) ? key_i : rk_q[cnt_q - 4'd1];
  assign t  = sub_word({prev[23:0], prev[31:24]}) ^ {rcon_q, 24'h0};
  assign w0 = prev[127:96] ^ t;
  assign w1 = prev[95:64] ^ w0;
  assign w2 = prev[63:32] ^ w1;
  assign w3 = prev[31:0] ^ w2;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rcon_d = rcon_q;
    if (restart_i) begin
      busy_d = 1'b1;
      cnt_d  = 4'd1;
      rcon_d = 8'h01;
    end else if (busy_q) begin
      cnt_d  = cnt_q + 4'd1;
      rcon_d = xtime(rcon_q);
      if (cnt_q == 4'(ROUND_COUNT)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= 4'd1;
      rcon_q <= 8'h01;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      rcon_q <= rcon_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !restart_i) begin
      if (cnt_q == 4'd1) begin
        rk_q[0] <= key_i;
      end
      rk_q[cnt_q] <= {w0, w1, w2, w3};
    end
  end

  assign round_key_o = rk_q[round_i];
  assign busy_o      = busy_q;
endmodule

// File: design/aes_round.sv
// Shared round unit: one AES round (forward or inverse) per cycle on a state register while step is set.
module aes_round (
  input  logic                clk_i,
  input  aes_pkg::core_ctrl_t ctrl_i,
  input  logic [127:0]        load_data_i,
  input  logic [127:0]        round_key_i,
  input  logic                last_round_i,
  output logic [127:0]        state_o
);
  import aes_pkg::*;

  logic [127:0] state_q, state_d;
  logic [7:0]   s [16];
  logic [7:0]   sb [16];
  logic [7:0]   sr [16];
  logic [7:0]   mc [16];
  logic [7:0]   ak [16];
  logic [7:0]   im [16];
  logic [7:0]   ish [16];
  logic [127:0] fwd_out, inv_out;

  // Byte i of the block sits at bits 127-8i.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_q[127-8*i -: 8];
    end
    // Forward: SubBytes, ShiftRows, MixColumns, AddRoundKey.
    for (int i = 0; i < 16; i++) begin
      sb[i] = fwd_sbox(s[i]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[4*c+r] = sb[4*((c+r)%4)+r];
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        mc[4*c+r] = xtime(sr[4*c+r]) ^ xtime(sr[4*c+(r+1)%4]) ^ sr[4*c+(r+1)%4]
                    ^ sr[4*c+(r+2)%4] ^ sr[4*c+(r+3)%4];
      end
    end
    for (int i = 0; i < 16; i++) begin
      ak[i] = (last_round_i ? sr[i] : mc[i]) ^ round_key_i[127-8*i -: 8];
      fwd_out[127-8*i -: 8] = ak[i];
    end
    // Inverse: AddRoundKey, InvMixColumns (skipped in the first round), InvShiftRows,
    // InvSubBytes.
    for (int i = 0; i < 16; i++) begin
      ak[i] = s[i] ^ round_key_i[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        logic [7:0] a0, a1, a2, a3, x2, x4, x8;
        a0 = ak[4*c+r];
        a1 = ak[4*c+(r+1)%4];
        a2 = ak[4*c+(r+2)%4];
        a3 = ak[4*c+(r+3)%4];
        // 0e*a0 ^ 0b*a1 ^ 0d*a2 ^ 09*a3
        x2 = xtime(a0); x4 = xtime(x2); x8 = xtime(x4);
        im[4*c+r] = x8 ^ x4 ^ x2;
        x2 = xtime(a1); x4 = xtime(x2); x8 = xtime(x4);
        im[4*c+r] = im[4*c+r] ^ x8 ^ x2 ^ a1;
        x2 = xtime(a2); x4 = xtime(x2); x8 = xtime(x4);
        im[4*c+r] = im[4*c+r] ^ x8 ^ x4 ^ a2;
        x2 = xtime(a3); x4 = xtime(x2); x8 = xtime(x4);
        im[4*c+r] = im[4*c+r] ^ x8 ^ a3;
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        ish[4*((c+r)%4)+r] = last_round_i ? ak[4*c+r] : im[4*c+r];
      end
    end
    for (int i = 0; i < 16; i++) begin
      inv_out[127-8*i -: 8] = inv_sbox(ish[i]);
    end
  end

  always_comb begin
    state_d = state_q;
    if (ctrl_i.load) begin
      state_d = load_data_i;
    end else if (ctrl_i.step) begin
      state_d = ctrl_i.decrypt ? inv_out : fwd_out;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
  end

  assign state_o = state_q;
endmodule

// File: design/aes128_block_cipher_ecb_cbc.sv
// AES-128 block engine, ECB or CBC, encrypt or decrypt, with an iterative round unit.
// One word (16-byte block) is accepted when the engine is idle. Encryption loads the
// block XOR round key 0 (plus the chaining value in CBC) and then runs ten rounds,
// one per cycle, in a single shared round unit; decryption loads the raw block and
// runs ten inverse rounds, the first of which skips InvMixColumns, followed by a
// round-key-0 add in the finish cycle. The finish state writes the block to the result
// register, and the engine takes a new word only once that is done. The next word
// may be accepted while a result still waits, but it cannot finish until that
// result has been taken. The round keys are held in flops and re-expanded, one round
// key per cycle, after reset and after every write of a key register; the input is
// held off during that expansion. In CBC mode the chaining value is reloaded from
// the IV when a word carries start, becomes the ciphertext after an encryption,
// and becomes the incoming ciphertext after a decryption. Mode registers are
// sampled when a word is accepted.
module aes128_block_cipher_ecb_cbc #(
  parameter int unsigned ROUND_COUNT = aes_pkg::RoundCount
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [aes_pkg::RegIdxW-1:0]         cfg_idx_i,
  input  logic [aes_pkg::CfgDataW-1:0]        cfg_data_i,
  aes_stream_if.sink                          in_if,
  aes_stream_if.source                        out_if
);
  import aes_pkg::*;

  logic [63:0]  key_high_q, key_low_q, iv_high_q, iv_low_q;
  logic         decrypt_q, chain_q;
  logic [127:0] cv_q;
  logic         dec_run_q, cbc_run_q, last_q;
  logic [127:0] ct_in_q;
  logic [3:0]   round_q, round_d;
  core_state_e  state_q, state_d;
  logic         key_wr, ks_busy, in_fire, out_fire;
  logic [127:0] rkey, blk, cv_use, core_state, finish_val;
  logic [3:0]   rk_idx;
  logic         last_round;
  core_ctrl_t   ctrl;
  logic         res_valid_q;
  logic [127:0] res_q;
  logic         res_last_q;

  assign key_wr   = cfg_we_i && (cfg_idx_i == REG_KEY_HIGH || cfg_idx_i == REG_KEY_LOW);
  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;
  assign blk      = {in_if.data_high, in_if.data_low};
  assign cv_use   = in_if.start ? {iv_high_q, iv_low_q} : cv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      iv_high_q  <= '0;
      iv_low_q   <= '0;
      decrypt_q  <= 1'b0;
      chain_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY_HIGH: key_high_q <= cfg_data_i;
        REG_KEY_LOW:  key_low_q  <= cfg_data_i;
        REG_IV_HIGH:  iv_high_q  <= cfg_data_i;
        REG_IV_LOW:   iv_low_q   <= cfg_data_i;
        REG_DECRYPT:  decrypt_q  <= cfg_data_i[0];
        REG_CHAIN:    chain_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The expansion starts in the cycle after a key write, from the updated registers.
  aes_key_exp #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_key_exp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       ({key_high_q, key_low_q}),
    .restart_i   (key_wr),
    .round_i     (rk_idx),
    .round_key_o (rkey),
    .busy_o      (ks_busy)
  );

  // Encryption walks round keys up from 1, decryption walks down from ten; in the
  // idle and finish states key 0 is selected for the initial/final key addition.
  always_comb begin
    rk_idx = 4'd0;
    if (state_q == ST_ROUND) begin
      rk_idx = dec_run_q ? 4'(ROUND_COUNT) - round_q : round_q + 4'd1;
    end
  end
  assign last_round = dec_run_q ? (round_q == 4'd0) : (round_q == 4'(ROUND_COUNT - 1));

  aes_round u_round (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .load_data_i  (decrypt_q ? blk : (blk ^ (chain_q ? cv_use : '0) ^ rkey)),
    .round_key_i  (rkey),
    .last_round_i (last_round),
    .state_o      (core_state)
  );

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    case (state_q)
      ST_IDLE: begin
        round_d = 4'd0;
        if (in_fire) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        round_d = round_q + 4'd1;
        if (round_q == 4'(ROUND_COUNT - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_valid_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.load    = (state_q == ST_IDLE) && in_fire;
    ctrl.step    = (state_q == ST_ROUND);
    ctrl.decrypt = dec_run_q;
    in_if.ready  = (state_q == ST_IDLE) && !ks_busy && !key_wr;
  end

  assign finish_val = dec_run_q ? (core_state ^ rkey ^ (cbc_run_q ? cv_q : '0)) : core_state;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      round_q     <= 4'd0;
      res_valid_q <= 1'b0;
      cv_q        <= '0;
      dec_run_q   <= 1'b0;
      cbc_run_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      if (ctrl.load) begin
        dec_run_q <= decrypt_q;
        cbc_run_q <= chain_q;
        if (in_if.start) begin
          cv_q <= {iv_high_q, iv_low_q};
        end
      end
      if (state_q == ST_DONE && !res_valid_q) begin
        res_valid_q <= 1'b1;
        if (cbc_run_q) begin
          cv_q <= dec_run_q ? ct_in_q : core_state;
        end
      end else if (out_fire) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      ct_in_q <= blk;
      last_q  <= in_if.last;
    end
    if (state_q == ST_DONE && !res_valid_q) begin
      res_q      <= finish_val;
      res_last_q <= last_q;
    end
  end

  assign out_if.valid     = res_valid_q;
  assign out_if.data_high = res_q[127:64];
  assign out_if.data_low  = res_q[63:0];
  assign out_if.start     = 1'b0;
  assign out_if.last      = res_last_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !in_if.ready) else $error("input accepted while busy");
  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROUND |-> round_q < 4'(ROUND_COUNT)) else $error("round overrun");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !out_if.ready |=> res_valid_q) else $error("result dropped");
  a_load_after_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load |=> state_q == ST_ROUND) else $error("load without round start");
endmodule
